// ===== hw/rtl/cnt_pkg.sv =====
// Shared types and constants of the coverage novelty tracker.
`timescale 1ns / 1ps

package cnt_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned EDGE_BITS = 17;
  localparam int unsigned FOUND_BITS = 18;
  localparam int unsigned HIT_BITS = 32;
  localparam logic [17:0] FOUND_MAX = 18'd131072;

  typedef enum logic [1:0] {
    OP_EVAL    = 2'd0,
    OP_RESTORE = 2'd1,
    OP_RESET   = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_COUNT = 2'd1,
    ST_VIRGIN   = 2'd2,
    ST_SPARE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] hit_count;
    logic [17:0] found_total;
    logic        scan_new;
    logic        scan_done;
    logic        last_of_run;
    logic [16:0] new_edge;
    logic        edge_valid;
  } res_t;

endpackage

// ===== hw/rtl/cnt_ram.sv =====
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps

module cnt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/cnt_ctrl.sv =====
// Sequencer that reads, updates and writes back the coverage maps and counters.
`timescale 1ns / 1ps

module cnt_ctrl
  import cnt_pkg::*;
#(
  parameter int unsigned MAP_WORDS = 2048,
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned AW = 11
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic                         in_crash,
  input  logic [10:0]                  in_wi,
  input  logic [WORD_BITS-1:0]         in_word,
  input  logic                         in_last,
  input  logic [EDGE_BITS-1:0]         in_ei,
  input  logic                         cfg_valid,
  input  logic                         cfg_bit,
  output logic                         out_valid,
  input  logic                         out_ready,
  output res_t                         out_res,
  output logic [AW-1:0]                rd_addr,
  output logic [AW-1:0]                wr_addr,
  output logic                         vmap_we,
  output logic [WORD_BITS-1:0]         vmap_wdata,
  input  logic [WORD_BITS-1:0]         vmap_rdata,
  output logic                         cmap_we,
  output logic [WORD_BITS-1:0]         cmap_wdata,
  input  logic [WORD_BITS-1:0]         cmap_rdata,
  output logic                         cnt_we,
  output logic [WORD_BITS*COUNT_BITS-1:0] cnt_wdata,
  input  logic [WORD_BITS*COUNT_BITS-1:0] cnt_rdata
);

  localparam int unsigned EDGE_SLOTS = MAP_WORDS * 64;
  localparam int unsigned ROW_BITS = WORD_BITS * COUNT_BITS;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RMW   = 5'b00010,
    S_EMIT  = 5'b00100,
    S_OUT   = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [AW:0] clr_addr_r, clr_addr_nxt;
  logic clr_resp_r, clr_resp_nxt;
  logic [17:0] found_r, found_nxt;
  logic seen_r, seen_nxt;
  logic track_r, track_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_res_r, out_res_nxt;

  op_t op_r;
  logic crash_r, last_r, any_r, any_nxt;
  logic [10:0] wi_r;
  logic [WORD_BITS-1:0] word_r;
  logic [EDGE_BITS-1:0] ei_r;
  logic [AW-1:0] addr_r;
  logic [WORD_BITS-1:0] fresh_r, fresh_nxt;
  res_t res_r, res_nxt;

  logic slot_free, accept;
  logic wi_ok, ei_ok;
  logic [5:0] bit_idx, low_idx;
  logic [WORD_BITS-1:0] map_q, fresh_c, rem_c, bit_mask;
  logic [COUNT_BITS-1:0] lane_q;
  logic [ROW_BITS-1:0] cnt_inc;
  logic [31:0] wi_ext, ei_ext;
  logic [AW-1:0] in_addr;

  always_comb begin
    low_idx = 6'd0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (fresh_r[i]) begin
        low_idx = 6'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      if (word_r[i]) begin
        cnt_inc[i*COUNT_BITS +: COUNT_BITS] = cnt_rdata[i*COUNT_BITS +: COUNT_BITS] + 1'b1;
      end else begin
        cnt_inc[i*COUNT_BITS +: COUNT_BITS] = cnt_rdata[i*COUNT_BITS +: COUNT_BITS];
      end
    end
  end

  assign wi_ext = 32'(wi_r);
  assign ei_ext = 32'(ei_r);
  assign wi_ok = wi_ext < MAP_WORDS;
  assign ei_ok = ei_ext < EDGE_SLOTS;
  assign bit_idx = ei_r[5:0];
  assign bit_mask = 64'd1 << bit_idx;
  assign map_q = crash_r ? cmap_rdata : vmap_rdata;
  assign fresh_c = wi_ok ? (word_r & map_q) : '0;
  assign rem_c = fresh_r & (fresh_r - 1'b1);
  assign lane_q = cnt_rdata[bit_idx*COUNT_BITS +: COUNT_BITS];

  always_comb begin
    logic [31:0] a;
    a = (op_t'(in_op) == OP_EVAL) ? 32'(in_wi) : (32'(in_ei) >> 6);
    in_addr = a[AW-1:0];
  end

  assign rd_addr = in_addr;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_res = out_res_r;

  always_comb begin
    state_nxt = state_r;
    clr_addr_nxt = clr_addr_r;
    clr_resp_nxt = clr_resp_r;
    found_nxt = found_r;
    seen_nxt = seen_r;
    track_nxt = cfg_valid ? cfg_bit : track_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt = out_res_r;
    fresh_nxt = fresh_r;
    any_nxt = any_r;
    res_nxt = res_r;
    wr_addr = addr_r;
    vmap_we = 1'b0;
    cmap_we = 1'b0;
    cnt_we = 1'b0;
    vmap_wdata = vmap_rdata;
    cmap_wdata = cmap_rdata;
    cnt_wdata = cnt_rdata;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RMW;
        end
      end
      S_RMW: begin
        res_nxt = '0;
        res_nxt.last_of_run = 1'b1;
        res_nxt.found_total = found_r;
        unique case (op_r)
          OP_EVAL: begin
            fresh_nxt = fresh_c;
            any_nxt = seen_r || (fresh_c != '0);
            seen_nxt = last_r ? 1'b0 : (seen_r || (fresh_c != '0));
            if (wi_ok) begin
              vmap_wdata = vmap_rdata & ~fresh_c;
              cmap_wdata = cmap_rdata & ~fresh_c;
              vmap_we = !crash_r;
              cmap_we = crash_r;
              cnt_wdata = cnt_inc;
              cnt_we = track_r;
            end
            state_nxt = S_EMIT;
          end
          OP_RESTORE: begin
            if (ei_ok) begin
              if ((vmap_rdata & bit_mask) != '0) begin
                res_nxt.status = ST_VIRGIN;
              end else begin
                vmap_wdata = vmap_rdata | bit_mask;
                vmap_we = 1'b1;
                cnt_wdata[bit_idx*COUNT_BITS +: COUNT_BITS] = '0;
                cnt_we = track_r;
                if (found_r != '0) begin
                  found_nxt = found_r - 1'b1;
                  res_nxt.found_total = found_r - 1'b1;
                end
              end
            end
            state_nxt = S_OUT;
          end
          OP_RESET: begin
            found_nxt = '0;
            seen_nxt = 1'b0;
            res_nxt.found_total = '0;
            clr_addr_nxt = '0;
            clr_resp_nxt = 1'b1;
            state_nxt = S_CLEAR;
          end
          OP_READ: begin
            if (!track_r) begin
              res_nxt.status = ST_NO_COUNT;
            end else if (ei_ok) begin
              res_nxt.hit_count = 32'(lane_q);
            end
            state_nxt = S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_EMIT: begin
        if (fresh_r == '0) begin
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_res_nxt = '0;
            out_res_nxt.last_of_run = 1'b1;
            out_res_nxt.scan_done = 1'b1;
            out_res_nxt.scan_new = any_r;
            out_res_nxt.found_total = found_r;
            state_nxt = S_IDLE;
          end
        end else if (slot_free) begin
          if (!crash_r && found_r < FOUND_MAX) begin
            found_nxt = found_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_res_nxt = '0;
          out_res_nxt.edge_valid = 1'b1;
          out_res_nxt.new_edge = {wi_r, low_idx};
          out_res_nxt.last_of_run = (rem_c == '0);
          out_res_nxt.scan_done = (rem_c == '0) && last_r;
          out_res_nxt.scan_new = (rem_c == '0) && last_r && any_r;
          out_res_nxt.found_total = found_nxt;
          fresh_nxt = rem_c;
          if (rem_c == '0) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt = res_r;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        wr_addr = clr_addr_r[AW-1:0];
        vmap_wdata = (clr_addr_r == '0) ? ~64'd1 : '1;
        cmap_wdata = vmap_wdata;
        cnt_wdata = '0;
        vmap_we = 1'b1;
        cmap_we = 1'b1;
        cnt_we = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (32'(clr_addr_r) == MAP_WORDS - 1) begin
          clr_resp_nxt = 1'b0;
          state_nxt = clr_resp_r ? S_OUT : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_addr_r <= '0;
      clr_resp_r <= 1'b0;
      found_r <= '0;
      seen_r <= 1'b0;
      track_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_resp_r <= clr_resp_nxt;
      found_r <= found_nxt;
      seen_r <= seen_nxt;
      track_r <= track_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_t'(in_op);
      crash_r <= in_crash;
      wi_r <= in_wi;
      word_r <= in_word;
      last_r <= in_last;
      ei_r <= in_ei;
      addr_r <= in_addr;
    end
    fresh_r <= fresh_nxt;
    any_r <= any_nxt;
    res_r <= res_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule

// ===== hw/rtl/coverage_novelty_tracker.sv =====
// Top level of the coverage novelty tracker: stream ports, maps and counter memory.
`timescale 1ns / 1ps

// Each input word takes one map read and one step of update and write-back, and then one
// output per newly found edge (or a summary at the end of a run, or a single answer for
// the other ops), each of which waits for room in the output slot; the next word is taken
// only after that. All of this runs through the single read-modify-write of the map and
// counter memories, which hold one bitmap word and its 64 hit counters per row. After reset,
// and after a reset op, a clearing pass over all MAP_WORDS rows runs before the next word is taken.

module coverage_novelty_tracker
  import cnt_pkg::*;
#(
  parameter int unsigned MAP_WORDS = 2048,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // use_crash_map, word_index, bitmap_word, edge_index, zero fill
  input  logic [95:0] in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  // edge_valid, new_edge, scan_done, scan_new, found_total, hit_count, status
  output logic [71:0] out_tdata,
  output logic        out_tlast
);

  localparam int unsigned AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned ROW_BITS = WORD_BITS * COUNT_BITS;

  logic [AW-1:0] rd_addr, wr_addr;
  logic vmap_we, cmap_we, cnt_we;
  logic [WORD_BITS-1:0] vmap_wdata, vmap_rdata, cmap_wdata, cmap_rdata;
  logic [ROW_BITS-1:0] cnt_wdata, cnt_rdata;
  res_t res;

  assign cfg_ready = 1'b1;

  cnt_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS), .AW(AW)) u_vmap (
    .clk(clk), .we(vmap_we), .waddr(wr_addr), .wdata(vmap_wdata),
    .raddr(rd_addr), .rdata(vmap_rdata)
  );

  cnt_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS), .AW(AW)) u_cmap (
    .clk(clk), .we(cmap_we), .waddr(wr_addr), .wdata(cmap_wdata),
    .raddr(rd_addr), .rdata(cmap_rdata)
  );

  cnt_ram #(.WIDTH(ROW_BITS), .DEPTH(MAP_WORDS), .AW(AW)) u_counts (
    .clk(clk), .we(cnt_we), .waddr(wr_addr), .wdata(cnt_wdata),
    .raddr(rd_addr), .rdata(cnt_rdata)
  );

  cnt_ctrl #(.MAP_WORDS(MAP_WORDS), .COUNT_BITS(COUNT_BITS), .AW(AW)) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .in_op(in_tuser),
    .in_crash(in_tdata[0]),
    .in_wi(in_tdata[11:1]),
    .in_word(in_tdata[75:12]),
    .in_last(in_tlast),
    .in_ei(in_tdata[92:76]),
    .cfg_valid(cfg_valid),
    .cfg_bit(cfg_data),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res(res),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .vmap_we(vmap_we),
    .vmap_wdata(vmap_wdata),
    .vmap_rdata(vmap_rdata),
    .cmap_we(cmap_we),
    .cmap_wdata(cmap_wdata),
    .cmap_rdata(cmap_rdata),
    .cnt_we(cnt_we),
    .cnt_wdata(cnt_wdata),
    .cnt_rdata(cnt_rdata)
  );

  assign out_tdata = {res.status, res.hit_count, res.found_total, res.scan_new,
                      res.scan_done, res.new_edge, res.edge_valid};
  assign out_tlast = res.last_of_run;

endmodule
